### sv/cau_pkg.sv
// cau_pkg: shared constants and codes for the complex arithmetic unit
// depends on nothing; used by complex_arithmetic_unit
`timescale 1ns / 1ps

package cau_pkg;

  localparam int PartWidth    = 16;
  localparam int FractionBits = 8;
  localparam int CmdWidth     = 2;
  localparam int StatusWidth  = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2,
    ST_RSV = 2'd3
  } status_e;

endpackage

### sv/complex_arithmetic_unit.sv
// complex_arithmetic_unit: pipelined complex add, subtract, multiply, divide
// depends on cau_pkg (constants, command and status codes)
//
//  channel  | ports                                       | handshake
//  ---------+---------------------------------------------+------------------------
//  command  | command_i, a_re_i, a_im_i, b_re_i, b_im_i   | start & !busy
//  result   | res_re_o, res_im_o, status_o                | result_valid_o, 1 cycle
//
// one item enters every cycle; every result passes the same stages whatever
// the command: multiply, sum and set-up stages, then the divider with one
// restoring quotient bit per stage, PART_WIDTH + 1 stages, then the output stage.
// busy is always low and the receiver cannot stall, so nothing ever waits.
// reset clears only the valid bits of the stages.
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
  parameter int PART_WIDTH    = cau_pkg::PartWidth,
  parameter int FRACTION_BITS = cau_pkg::FractionBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [cau_pkg::CmdWidth-1:0]        command_i,
  input  logic signed [PART_WIDTH-1:0]        a_re_i,
  input  logic signed [PART_WIDTH-1:0]        a_im_i,
  input  logic signed [PART_WIDTH-1:0]        b_re_i,
  input  logic signed [PART_WIDTH-1:0]        b_im_i,
  output logic                                result_valid_o,
  output logic signed [PART_WIDTH-1:0]        res_re_o,
  output logic signed [PART_WIDTH-1:0]        res_im_o,
  output logic [cau_pkg::StatusWidth-1:0]     status_o
);

  localparam int W  = PART_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * W;           // product width
  localparam int SW = 2 * W + 1;       // sum of products width
  localparam int NQ = W + 1;           // quotient bits kept
  localparam int DW = 3 * W + F + 2;   // divider remainder width

  // saturate a sign and magnitude to one part; top bit flags saturation
  function automatic logic [W:0] sat_fn(input logic neg, input logic [SW-1:0] mag);
    logic [SW-1:0] lim;
    logic [W:0]    r;
    lim = SW'(1) << (W - 1);
    if (neg) begin
      if (mag > lim) r = {1'b1, lim[W-1:0]};
      else           r = {1'b0, W'(SW'(0) - mag)};
    end else begin
      if (mag >= lim) r = {1'b1, W'(lim - SW'(1))};
      else            r = {1'b0, mag[W-1:0]};
    end
    return r;
  endfunction

  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // stage 1: products and add/subtract
  logic signed [PW-1:0] ar_x, ai_x, br_x, bi_x;
  assign ar_x = PW'(a_re_i);
  assign ai_x = PW'(a_im_i);
  assign br_x = PW'(b_re_i);
  assign bi_x = PW'(b_im_i);

  logic                 s1_valid_q;
  cau_pkg::cmd_e        s1_cmd_q;
  logic signed [PW-1:0] s1_rr_q, s1_ii_q, s1_ri_q, s1_ir_q, s1_bb_q, s1_cc_q;
  logic signed [W:0]    s1_sre_q, s1_sim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q <= cau_pkg::cmd_e'(command_i);
    s1_rr_q  <= ar_x * br_x;
    s1_ii_q  <= ai_x * bi_x;
    s1_ri_q  <= ar_x * bi_x;
    s1_ir_q  <= ai_x * br_x;
    s1_bb_q  <= br_x * br_x;
    s1_cc_q  <= bi_x * bi_x;
    if (command_i == cau_pkg::CMD_SUB) begin
      s1_sre_q <= (W+1)'(a_re_i) - (W+1)'(b_re_i);
      s1_sim_q <= (W+1)'(a_im_i) - (W+1)'(b_im_i);
    end else begin
      s1_sre_q <= (W+1)'(a_re_i) + (W+1)'(b_re_i);
      s1_sim_q <= (W+1)'(a_im_i) + (W+1)'(b_im_i);
    end
  end

  // stage 2: sums of products and divisor
  logic                 s2_valid_q;
  cau_pkg::cmd_e        s2_cmd_q;
  logic signed [SW-1:0] s2_re_q, s2_im_q;
  logic [PW-1:0]        s2_d_q;
  logic signed [W:0]    s2_sre_q, s2_sim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else         s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    s2_cmd_q <= s1_cmd_q;
    s2_d_q   <= PW'(s1_bb_q) + PW'(s1_cc_q);
    s2_sre_q <= s1_sre_q;
    s2_sim_q <= s1_sim_q;
    if (s1_cmd_q == cau_pkg::CMD_DIV) begin
      s2_re_q <= SW'(s1_rr_q) + SW'(s1_ii_q);
      s2_im_q <= SW'(s1_ir_q) - SW'(s1_ri_q);
    end else begin
      s2_re_q <= SW'(s1_rr_q) - SW'(s1_ii_q);
      s2_im_q <= SW'(s1_ri_q) + SW'(s1_ir_q);
    end
  end

  // stage 3: finish add, sub and mul; set up the divider
  logic          re_neg, im_neg;
  logic [SW-1:0] re_mag, im_mag;
  logic [W:0]    asr_x, asi_x;
  logic [W:0]    fin_re, fin_im;
  logic [SW-1:0] as_re_mag, as_im_mag;
  logic [DW-1:0] d_top;

  assign re_neg    = s2_re_q[SW-1];
  assign im_neg    = s2_im_q[SW-1];
  assign re_mag    = re_neg ? SW'(0) - s2_re_q : s2_re_q;
  assign im_mag    = im_neg ? SW'(0) - s2_im_q : s2_im_q;
  assign as_re_mag = s2_sre_q[W] ? SW'(-s2_sre_q) : SW'(s2_sre_q);
  assign as_im_mag = s2_sim_q[W] ? SW'(-s2_sim_q) : SW'(s2_sim_q);
  assign asr_x     = sat_fn(s2_sre_q[W], as_re_mag);
  assign asi_x     = sat_fn(s2_sim_q[W], as_im_mag);
  assign d_top     = DW'(s2_d_q) << NQ;

  always_comb begin
    case (s2_cmd_q)
      cau_pkg::CMD_MUL: begin
        fin_re = sat_fn(re_neg, SW'(re_mag >> F));
        fin_im = sat_fn(im_neg, SW'(im_mag >> F));
      end
      default: begin
        fin_re = asr_x;
        fin_im = asi_x;
      end
    endcase
  end

  // divider pipe registers, entry 0 fed by stage 3
  logic                 dv_valid_q [NQ+1];
  cau_pkg::cmd_e        dv_cmd_q   [NQ+1];
  logic [W-1:0]         dv_pre_q   [NQ+1];
  logic [W-1:0]         dv_pim_q   [NQ+1];
  logic                 dv_psat_q  [NQ+1];
  logic [PW-1:0]        dv_d_q     [NQ+1];
  logic [DW-1:0]        dv_rre_q   [NQ+1];
  logic [DW-1:0]        dv_rim_q   [NQ+1];
  logic [NQ-1:0]        dv_qre_q   [NQ+1];
  logic [NQ-1:0]        dv_qim_q   [NQ+1];
  logic                 dv_nre_q   [NQ+1];
  logic                 dv_nim_q   [NQ+1];
  logic                 dv_bre_q   [NQ+1];
  logic                 dv_bim_q   [NQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_valid_q[0] <= 1'b0;
    else         dv_valid_q[0] <= s2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    dv_cmd_q[0]  <= s2_cmd_q;
    dv_pre_q[0]  <= fin_re[W-1:0];
    dv_pim_q[0]  <= fin_im[W-1:0];
    dv_psat_q[0] <= fin_re[W] | fin_im[W];
    dv_d_q[0]    <= s2_d_q;
    dv_rre_q[0]  <= DW'(re_mag) << F;
    dv_rim_q[0]  <= DW'(im_mag) << F;
    dv_qre_q[0]  <= '0;
    dv_qim_q[0]  <= '0;
    dv_nre_q[0]  <= re_neg;
    dv_nim_q[0]  <= im_neg;
    dv_bre_q[0]  <= (DW'(re_mag) << F) >= d_top;
    dv_bim_q[0]  <= (DW'(im_mag) << F) >= d_top;
  end

  // restoring division, one quotient bit per stage for both parts
  for (genvar i = 0; i < NQ; i++) begin : g_div
    localparam int B = NQ - 1 - i;
    logic [DW-1:0] sub;
    logic          ge_re, ge_im;
    assign sub   = DW'(dv_d_q[i]) << B;
    assign ge_re = dv_rre_q[i] >= sub;
    assign ge_im = dv_rim_q[i] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_valid_q[i+1] <= 1'b0;
      else         dv_valid_q[i+1] <= dv_valid_q[i];
    end

    always_ff @(posedge clk_i) begin
      dv_cmd_q[i+1]  <= dv_cmd_q[i];
      dv_pre_q[i+1]  <= dv_pre_q[i];
      dv_pim_q[i+1]  <= dv_pim_q[i];
      dv_psat_q[i+1] <= dv_psat_q[i];
      dv_d_q[i+1]    <= dv_d_q[i];
      dv_nre_q[i+1]  <= dv_nre_q[i];
      dv_nim_q[i+1]  <= dv_nim_q[i];
      dv_bre_q[i+1]  <= dv_bre_q[i];
      dv_bim_q[i+1]  <= dv_bim_q[i];
      dv_rre_q[i+1]  <= ge_re ? dv_rre_q[i] - sub : dv_rre_q[i];
      dv_rim_q[i+1]  <= ge_im ? dv_rim_q[i] - sub : dv_rim_q[i];
      dv_qre_q[i+1]  <= dv_qre_q[i] | (NQ'(ge_re) << B);
      dv_qim_q[i+1]  <= dv_qim_q[i] | (NQ'(ge_im) << B);
    end
  end

  // output stage: saturate quotients and pick the result
  logic [W:0]    qs_re, qs_im;
  logic [W-1:0]  res_re_d, res_im_d;
  logic [cau_pkg::StatusWidth-1:0] status_d;

  assign qs_re = dv_bre_q[NQ] ? sat_fn(dv_nre_q[NQ], {SW{1'b1}})
                              : sat_fn(dv_nre_q[NQ], SW'(dv_qre_q[NQ]));
  assign qs_im = dv_bim_q[NQ] ? sat_fn(dv_nim_q[NQ], {SW{1'b1}})
                              : sat_fn(dv_nim_q[NQ], SW'(dv_qim_q[NQ]));

  always_comb begin
    res_re_d = dv_pre_q[NQ];
    res_im_d = dv_pim_q[NQ];
    status_d = dv_psat_q[NQ] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    if (dv_cmd_q[NQ] == cau_pkg::CMD_DIV) begin
      if (dv_d_q[NQ] == '0) begin
        res_re_d = '0;
        res_im_d = '0;
        status_d = cau_pkg::ST_DZ;
      end else begin
        res_re_d = qs_re[W-1:0];
        res_im_d = qs_im[W-1:0];
        status_d = (qs_re[W] | qs_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  logic                            out_valid_q;
  logic [W-1:0]                    out_re_q, out_im_q;
  logic [cau_pkg::StatusWidth-1:0] out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= dv_valid_q[NQ];
  end

  always_ff @(posedge clk_i) begin
    out_re_q     <= res_re_d;
    out_im_q     <= res_im_d;
    out_status_q <= status_d;
  end

  assign result_valid_o = out_valid_q;
  assign res_re_o       = out_re_q;
  assign res_im_o       = out_im_q;
  assign status_o       = out_status_q;

endmodule
